// ----- hw/rtl/lpbl_pkg.sv -----
`default_nettype none
package lpbl_pkg;

	localparam int MAX_PARTITIONS = 256;
	localparam int MAX_LATTICE_SIDE = 16;
	localparam int BOUND_WORDS = 8;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_GLOBAL = 2'd1;
	localparam logic [1:0] MODE_NEIGHBOR = 2'd2;

	localparam logic [2:0] CFG_SIZE_I = 3'd0;
	localparam logic [2:0] CFG_SIZE_J = 3'd1;
	localparam logic [2:0] CFG_SIZE_K = 3'd2;
	localparam logic [2:0] CFG_SIZE_T = 3'd3;
	localparam logic [2:0] CFG_COUNT = 3'd4;

	typedef struct packed {
		logic [1:0]         mode;
		logic [7:0]         entry_rank;
		logic [2:0]         bound_select;
		logic signed [15:0] bound_value;
		logic [7:0]         home_rank;
		logic signed [23:0] point_x;
		logic signed [23:0] point_y;
		logic signed [23:0] point_z;
		logic signed [23:0] point_time;
	} in_t;

	typedef struct packed {
		logic       found;
		logic [7:0] found_rank;
		logic [3:0] index_i;
		logic [3:0] index_j;
		logic [3:0] index_k;
		logic [3:0] index_t;
	} out_t;

	typedef logic [BOUND_WORDS-1:0][15:0] bounds_t;

	typedef struct packed {
		logic       act;
		logic       cand;
		logic       last;
		logic [7:0] rank;
		logic [3:0] idx_i;
		logic [3:0] idx_j;
		logic [3:0] idx_k;
		logic [3:0] idx_t;
	} tag_t;

	typedef struct packed {
		tag_t             tag;
		logic [3:0][15:0] lo;
		logic [3:0][15:0] hi;
		logic [3:0][23:0] pt;
	} slot_t;

	function automatic logic [4:0] eff_side(input logic [4:0] s);
		if (s == 5'd0) begin
			return 5'd1;
		end else if (s > 5'(MAX_LATTICE_SIDE)) begin
			return 5'(MAX_LATTICE_SIDE);
		end
		return s;
	endfunction

	function automatic logic [8:0] eff_count(input logic [8:0] c);
		if (c > 9'(MAX_PARTITIONS)) begin
			return 9'(MAX_PARTITIONS);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/lpbl_bound_ram.sv -----
`default_nettype none
module lpbl_bound_ram (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [2:0]       wr_sel,
	input  wire logic [7:0]       wr_addr,
	input  wire logic [15:0]      wr_data,
	input  wire logic [7:0]       rd_addr,
	output lpbl_pkg::bounds_t     rd_data
);

	logic [15:0] mem [lpbl_pkg::BOUND_WORDS][lpbl_pkg::MAX_PARTITIONS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_sel][wr_addr] <= wr_data;
		end
		for (int b = 0; b < lpbl_pkg::BOUND_WORDS; b++) begin
			rd_data[b] <= mem[b][rd_addr];
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/lpbl_axis_cell.sv -----
`default_nettype none
module lpbl_axis_cell (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             flush,
	input  wire lpbl_pkg::slot_t  din,
	output lpbl_pkg::slot_t       dout
);

	logic            act_q;
	lpbl_pkg::slot_t pay_q;
	lpbl_pkg::slot_t pay_d;
	logic            pass;

	// compare head axis, then shift the next axis into place
	assign pass = ($signed({din.lo[0], 8'h00}) <= $signed(din.pt[0])) &&
		($signed(din.pt[0]) <= $signed({din.hi[0], 8'h00}));

	always_comb begin
		pay_d = din;
		pay_d.tag.cand = din.tag.cand && pass;
		pay_d.lo = {16'h0000, din.lo[3:1]};
		pay_d.hi = {16'h0000, din.hi[3:1]};
		pay_d.pt = {24'h000000, din.pt[3:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else begin
			act_q <= din.tag.act && !flush;
		end
	end

	always_ff @(posedge clk) begin
		pay_q <= pay_d;
	end

	always_comb begin
		dout = pay_q;
		dout.tag.act = act_q;
	end

endmodule
`default_nettype wire

// ----- hw/rtl/lattice_point_block_locator.sv -----
`default_nettype none
// Point-in-box lookup over a table of 4D partition boxes. A mode 0 word writes one bound
// word. A global locate (mode 1) walks the ranks from 0 up, one rank issued per cycle
// into a bound memory with one read port per bank followed by a chain of four axis
// compare cells; it ends early when a hit comes. A neighbour locate (mode 2) first
// counts up to the home rank and then issues the 81 offsets one per cycle; a home rank
// at or beyond the partition count gives a miss with no scan. The rate is set by the
// single read of the bound memory per cycle. The table holds no reset value.
module lattice_point_block_locator (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire lpbl_pkg::in_t  req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output lpbl_pkg::out_t      rsp,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic [2:0]     cfg_index,
	input  wire logic [8:0]     cfg_data
);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_PLANE  = 8'b0000_0010,
		ST_CUBE   = 8'b0000_0100,
		ST_GSCAN  = 8'b0000_1000,
		ST_DECOMP = 8'b0001_0000,
		ST_NSCAN  = 8'b0010_0000,
		ST_DRAIN  = 8'b0100_0000,
		ST_RESULT = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [4:0] size_i_q, size_j_q, size_k_q, size_t_q;
	logic [8:0] count_q;
	logic [4:0] si, sj, sk, st;
	logic [8:0] n;
	lpbl_pkg::in_t req_q;
	logic [8:0] plane_q;
	logic [12:0] cube_q;
	logic [8:0] cnt_q;
	logic [3:0] ci_q, cj_q, ck_q;
	logic [7:0] ct_q;
	logic [3:0] hi_q, hj_q, hk_q;
	logic [7:0] ht_q;
	logic [1:0] di_q, dj_q, dk_q, dt_q;
	logic signed [17:0] off_q;
	lpbl_pkg::out_t res_q;
	logic rsp_valid_q;
	lpbl_pkg::out_t rsp_q;
	lpbl_pkg::tag_t tag_s1;
	logic act_s1;

	logic accept;
	logic wr_en;
	lpbl_pkg::bounds_t rd_data;
	lpbl_pkg::tag_t iss;
	logic [7:0] iss_addr;
	lpbl_pkg::slot_t chain [5];
	logic hit, done, flush, load;
	logic [4:0] ni, nj, nk;
	logic signed [9:0] na, nb, nc, nd;
	logic signed [17:0] nr, delta, si18, pl18, cu18;
	logic in_lat, self_pos, last_pos;

	assign si = lpbl_pkg::eff_side(size_i_q);
	assign sj = lpbl_pkg::eff_side(size_j_q);
	assign sk = lpbl_pkg::eff_side(size_k_q);
	assign st = lpbl_pkg::eff_side(size_t_q);
	assign n = lpbl_pkg::eff_count(count_q);

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != ST_IDLE);
	assign accept = req_valid && !req_stall;
	assign wr_en = accept && (req.mode == lpbl_pkg::MODE_WRITE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_i_q <= 5'd1;
			size_j_q <= 5'd1;
			size_k_q <= 5'd1;
			size_t_q <= 5'd1;
			count_q <= 9'd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				lpbl_pkg::CFG_SIZE_I: size_i_q <= cfg_data[4:0];
				lpbl_pkg::CFG_SIZE_J: size_j_q <= cfg_data[4:0];
				lpbl_pkg::CFG_SIZE_K: size_k_q <= cfg_data[4:0];
				lpbl_pkg::CFG_SIZE_T: size_t_q <= cfg_data[4:0];
				lpbl_pkg::CFG_COUNT: count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// rank counter step with lattice index carry
	assign ni = {1'b0, ci_q} + 5'd1;
	assign nj = {1'b0, cj_q} + 5'd1;
	assign nk = {1'b0, ck_q} + 5'd1;

	// neighbour position for the current offset
	assign na = $signed({6'd0, hi_q}) + $signed({8'd0, di_q}) - 10'sd1;
	assign nb = $signed({6'd0, hj_q}) + $signed({8'd0, dj_q}) - 10'sd1;
	assign nc = $signed({6'd0, hk_q}) + $signed({8'd0, dk_q}) - 10'sd1;
	assign nd = $signed({2'd0, ht_q}) + $signed({8'd0, dt_q}) - 10'sd1;
	assign in_lat = (na >= 0) && (na < $signed({5'd0, si})) &&
		(nb >= 0) && (nb < $signed({5'd0, sj})) &&
		(nc >= 0) && (nc < $signed({5'd0, sk})) &&
		(nd >= 0) && (nd < $signed({5'd0, st}));
	assign self_pos = (di_q == 2'd1) && (dj_q == 2'd1) && (dk_q == 2'd1) && (dt_q == 2'd1);
	assign last_pos = (di_q == 2'd2) && (dj_q == 2'd2) && (dk_q == 2'd2) && (dt_q == 2'd2);
	assign nr = $signed({10'd0, req_q.home_rank}) + off_q;
	assign si18 = $signed({13'd0, si});
	assign pl18 = $signed({9'd0, plane_q});
	assign cu18 = $signed({5'd0, cube_q});

	always_comb begin
		if (di_q != 2'd2) begin
			delta = 18'sd1;
		end else if (dj_q != 2'd2) begin
			delta = si18 - 18'sd2;
		end else if (dk_q != 2'd2) begin
			delta = pl18 - (si18 <<< 1) - 18'sd2;
		end else begin
			delta = cu18 - (pl18 <<< 1) - (si18 <<< 1) - 18'sd2;
		end
	end

	always_comb begin
		iss = '0;
		iss_addr = cnt_q[7:0];
		if (state_q == ST_GSCAN) begin
			iss.act = !done;
			iss.cand = (cnt_q < n);
			iss.last = ((cnt_q + 9'd1) >= n);
			iss.rank = cnt_q[7:0];
			iss.idx_i = ci_q;
			iss.idx_j = cj_q;
			iss.idx_k = ck_q;
			iss.idx_t = ct_q[3:0];
		end else if (state_q == ST_NSCAN) begin
			iss.act = !done;
			iss.cand = in_lat && !self_pos && (nr < $signed({9'd0, n}));
			iss.last = last_pos;
			iss.rank = nr[7:0];
			iss.idx_i = na[3:0];
			iss.idx_j = nb[3:0];
			iss.idx_k = nc[3:0];
			iss.idx_t = nd[3:0];
			iss_addr = nr[7:0];
		end
	end

	lpbl_bound_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_sel  (req.bound_select),
		.wr_addr (req.entry_rank),
		.wr_data (req.bound_value),
		.rd_addr (iss_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
		end else begin
			act_s1 <= iss.act && !flush;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= iss;
	end

	always_comb begin
		chain[0].tag = tag_s1;
		chain[0].tag.act = act_s1;
		chain[0].lo = {rd_data[6], rd_data[2], rd_data[1], rd_data[0]};
		chain[0].hi = {rd_data[7], rd_data[5], rd_data[4], rd_data[3]};
		chain[0].pt = {req_q.point_time, req_q.point_z, req_q.point_y, req_q.point_x};
	end

	for (genvar g = 0; g < 4; g++) begin : g_cell
		lpbl_axis_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.flush  (flush),
			.din    (chain[g]),
			.dout   (chain[g+1])
		);
	end

	assign hit = chain[4].tag.act && chain[4].tag.cand;
	assign done = hit || (chain[4].tag.act && chain[4].tag.last);
	assign flush = done;
	assign load = (state_q == ST_RESULT) && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (req.mode == lpbl_pkg::MODE_GLOBAL ||
						req.mode == lpbl_pkg::MODE_NEIGHBOR)) begin
						state_q <= ST_PLANE;
					end
				end
				ST_PLANE: state_q <= ST_CUBE;
				ST_CUBE: begin
					if (req_q.mode == lpbl_pkg::MODE_GLOBAL) begin
						state_q <= ST_GSCAN;
					end else if ({1'b0, req_q.home_rank} >= n) begin
						state_q <= ST_RESULT;
					end else begin
						state_q <= ST_DECOMP;
					end
				end
				ST_GSCAN: begin
					if (done) begin
						state_q <= ST_RESULT;
					end else if (iss.last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DECOMP: begin
					if (cnt_q[7:0] == req_q.home_rank) begin
						state_q <= ST_NSCAN;
					end
				end
				ST_NSCAN: begin
					if (done) begin
						state_q <= ST_RESULT;
					end else if (iss.last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (done) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (state_q == ST_PLANE) begin
			plane_q <= 9'(si * sj);
		end
		if (state_q == ST_CUBE) begin
			cube_q <= 13'(plane_q * sk);
			cnt_q <= '0;
			ci_q <= '0;
			cj_q <= '0;
			ck_q <= '0;
			ct_q <= '0;
			res_q <= '0;
		end
		if (state_q == ST_GSCAN || state_q == ST_DECOMP) begin
			cnt_q <= cnt_q + 9'd1;
			if (ni == si) begin
				ci_q <= '0;
				if (nj == sj) begin
					cj_q <= '0;
					if (nk == sk) begin
						ck_q <= '0;
						ct_q <= ct_q + 8'd1;
					end else begin
						ck_q <= nk[3:0];
					end
				end else begin
					cj_q <= nj[3:0];
				end
			end else begin
				ci_q <= ni[3:0];
			end
		end
		if (state_q == ST_DECOMP) begin
			hi_q <= ci_q;
			hj_q <= cj_q;
			hk_q <= ck_q;
			ht_q <= ct_q;
			di_q <= '0;
			dj_q <= '0;
			dk_q <= '0;
			dt_q <= '0;
			off_q <= -cu18 - pl18 - si18 - 18'sd1;
		end
		if (state_q == ST_NSCAN) begin
			off_q <= off_q + delta;
			if (di_q != 2'd2) begin
				di_q <= di_q + 2'd1;
			end else begin
				di_q <= '0;
				if (dj_q != 2'd2) begin
					dj_q <= dj_q + 2'd1;
				end else begin
					dj_q <= '0;
					if (dk_q != 2'd2) begin
						dk_q <= dk_q + 2'd1;
					end else begin
						dk_q <= '0;
						dt_q <= dt_q + 2'd1;
					end
				end
			end
		end
		if (done && hit) begin
			res_q.found <= 1'b1;
			res_q.found_rank <= chain[4].tag.rank;
			res_q.index_i <= chain[4].tag.idx_i;
			res_q.index_j <= chain[4].tag.idx_j;
			res_q.index_k <= chain[4].tag.idx_k;
			res_q.index_t <= chain[4].tag.idx_t;
		end
		if (load) begin
			rsp_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_issue_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		iss.act |-> (state_q == ST_GSCAN || state_q == ST_NSCAN))
		else $error("candidate issued outside a scan");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.found) |-> (rsp.found_rank == 8'd0 && rsp.index_i == 4'd0 &&
		rsp.index_j == 4'd0 && rsp.index_k == 4'd0 && rsp.index_t == 4'd0))
		else $error("miss word carries nonzero fields");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !act_s1 && !chain[4].tag.act)
		else $error("compare chain not cleared after a result");

endmodule
`default_nettype wire
